// File: rtl/sorted_priority_queue_top_assert.svh
// Assertion macros for the sorted priority queue.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sorted priority queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sorted priority queue: next-cycle check failed");

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [4:0]         count;
    } out_word_t;

endpackage

// File: rtl/spq_mem.sv
module spq_mem #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [$clog2(DEPTH)-1:0]              wr_addr,
    input  logic signed [VALUE_WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0]              rd_addr,
    output logic signed [VALUE_WIDTH-1:0]         rd_data
);

    logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/spq_seq.sv
module spq_seq #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  spq_pkg::in_word_t             in_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output spq_pkg::out_word_t            res_data,
    output logic                          mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
    output logic signed [VALUE_WIDTH-1:0] mem_wr_data,
    output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
    input  logic signed [VALUE_WIDTH-1:0] mem_rd_data
);

    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_STEP,
        S_INS_PUT,
        S_DEL_HEAD,
        S_DEL_STEP,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 occ_reg, occ_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    out_word_t                     res_reg, res_next;
    logic signed [VALUE_WIDTH-1:0] in_val;
    logic                          greater;

    assign in_val  = VALUE_WIDTH'(in_data.value);
    assign greater = mem_rd_data > val_reg;

    always_comb begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        res_next    = res_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = val_reg;
        mem_rd_addr = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    res_next.removed_value = '0;
                    res_next.status        = ST_OK;
                    res_next.count         = 5'(occ_reg);
                    if (in_data.op == OP_INSERT) begin
                        if (occ_reg == CW'(DEPTH)) begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end else if (occ_reg == '0) begin
                            mem_wr_en      = 1'b1;
                            mem_wr_addr    = '0;
                            mem_wr_data    = in_val;
                            occ_next       = occ_reg + CW'(1);
                            res_next.count = 5'(occ_reg + CW'(1));
                            state_next     = S_DONE;
                        end else begin
                            val_next    = in_val;
                            idx_next    = occ_reg;
                            mem_rd_addr = AW'(occ_reg - CW'(1));
                            state_next  = S_INS_STEP;
                        end
                    end else begin
                        if (occ_reg == '0) begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end else begin
                            mem_rd_addr = '0;
                            idx_next    = CW'(1);
                            state_next  = S_DEL_HEAD;
                        end
                    end
                end
            end
            S_INS_STEP: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(idx_reg);
                if (greater) begin
                    mem_wr_data = mem_rd_data;
                    idx_next    = idx_reg - CW'(1);
                    if (idx_reg == CW'(1)) begin
                        state_next = S_INS_PUT;
                    end else begin
                        mem_rd_addr = AW'(idx_reg - CW'(2));
                    end
                end else begin
                    mem_wr_data    = val_reg;
                    occ_next       = occ_reg + CW'(1);
                    res_next.count = 5'(occ_reg + CW'(1));
                    state_next     = S_DONE;
                end
            end
            S_INS_PUT: begin
                mem_wr_en      = 1'b1;
                mem_wr_addr    = '0;
                mem_wr_data    = val_reg;
                occ_next       = occ_reg + CW'(1);
                res_next.count = 5'(occ_reg + CW'(1));
                state_next     = S_DONE;
            end
            S_DEL_HEAD: begin
                res_next.removed_value = 32'($unsigned(mem_rd_data));
                if (occ_reg == CW'(1)) begin
                    occ_next       = occ_reg - CW'(1);
                    res_next.count = 5'(occ_reg - CW'(1));
                    state_next     = S_DONE;
                end else begin
                    mem_rd_addr = AW'(idx_reg);
                    state_next  = S_DEL_STEP;
                end
            end
            S_DEL_STEP: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(idx_reg - CW'(1));
                mem_wr_data = mem_rd_data;
                idx_next    = idx_reg + CW'(1);
                if (idx_reg + CW'(1) == occ_reg) begin
                    occ_next       = occ_reg - CW'(1);
                    res_next.count = 5'(occ_reg - CW'(1));
                    state_next     = S_DONE;
                end else begin
                    mem_rd_addr = AW'(idx_reg + CW'(1));
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
        idx_reg <= idx_next;
        val_reg <= val_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_data  = res_reg;

endmodule

// File: rtl/sorted_priority_queue_top.sv
// Ascending priority queue over a sorted memory of DEPTH signed values.
// Input channel s_*: one word per operation, op selects insert or remove of
// the smallest value. Result channel m_*: exactly one word per input word,
// carrying the removed value, a status code and the occupancy afterwards.
// Equal values leave in the order they were inserted.
// An insert walks down from the top of the queue with one comparator,
// moving each larger entry up one slot, one entry per cycle through the
// memory's read and write ports. A remove reads the head and then moves
// each remaining entry down one slot. Once the sequencer finishes, its
// result is loaded into m_data when the output register is free, and
// s_ready, low until then, rises in the same cycle as the result appears.
// Reset empties the queue; stored values are not cleared and need no pass.
// When the receiver stalls, the finished word waits in the output register
// and the next operation is processed; its result is then held back in the
// sequencer until the output register frees.
module sorted_priority_queue_top #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spq_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spq_pkg::out_word_t m_data
);

    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                          res_valid;
    logic                          out_free;
    out_word_t                     res_data;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    logic signed [VALUE_WIDTH-1:0] mem_wr_data;
    logic [AW-1:0]                 mem_rd_addr;
    logic signed [VALUE_WIDTH-1:0] mem_rd_data;
    logic                          m_valid_reg;
    out_word_t                     m_data_reg;

    spq_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .res_valid   (res_valid),
        .res_ready   (out_free),
        .res_data    (res_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    spq_mem #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && out_free) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "sorted_priority_queue_top_assert.svh"

    `SPQ_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `SPQ_ASSERT_NEXT(a_result_held, res_valid && !out_free, res_valid)
    `SPQ_ASSERT_SAME(a_reject_no_value, m_valid && (m_data.status != ST_OK),
        m_data.removed_value == 32'sd0)
    `SPQ_ASSERT_SAME(a_idle_no_result, s_ready, !res_valid)

endmodule

// File: tb/tb_sorted_priority_queue_top.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue_top;
    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;
    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_LO    = 250;
    localparam int QUIET_HI    = 400;
    localparam int IDLE_PCT    = 21;
    localparam int MAX_REPORTS = 50;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];

    logic signed [31:0] held_vals [DEPTH];
    int held = 0;

    int words_sent      = 0;
    int results_checked = 0;
    int inserts_ok      = 0;
    int removes_ok      = 0;
    int full_rejects    = 0;
    int empty_removes   = 0;
    int error_count     = 0;
    int cycles          = 0;

    sorted_priority_queue_top #(
        .DEPTH(DEPTH),
        .VALUE_WIDTH(32)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("t=%0t result %0d: %s got %0d expected %0d",
                     $realtime, results_checked, field, got, want);
        end
    endtask

    task automatic add_word(input logic op, input logic signed [31:0] value);
        in_word_t w;
        w.op    = op;
        w.value = value;
        pending_words.push_back(w);
    endtask

    // The queue is kept compact and ascending; an insert goes after all equal values.
    task automatic predict_queue_op(input in_word_t w);
        out_word_t r;
        int pos;
        r = '0;
        r.status = ST_OK;
        if (w.op == OP_INSERT) begin
            if (held == DEPTH) begin
                r.status = ST_FULL;
                full_rejects++;
            end else begin
                pos = 0;
                while (pos < held && $signed(held_vals[pos]) <= $signed(w.value)) begin
                    pos++;
                end
                for (int i = held; i > pos; i--) begin
                    held_vals[i] = held_vals[i - 1];
                end
                held_vals[pos] = w.value;
                held++;
                inserts_ok++;
            end
        end else begin
            if (held == 0) begin
                r.status = ST_EMPTY;
                empty_removes++;
            end else begin
                r.removed_value = held_vals[0];
                for (int i = 1; i < held; i++) begin
                    held_vals[i - 1] = held_vals[i];
                end
                held--;
                removes_ok++;
            end
        end
        r.count = 5'(held);
        expected_words.push_back(r);
    endtask

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
            default: return $signed($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin : drive
        in_word_t nxt;
        logic     nxt_valid;
        logic     quiet;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt       = s_data;
            if (s_valid && s_ready) begin
                predict_queue_op(s_data);
                words_sent++;
                nxt_valid = 1'b0;
            end
            quiet = (words_sent >= QUIET_LO) && (words_sent < QUIET_HI);
            if (!nxt_valid && pending_words.size() > 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt       = pending_words.pop_front();
                nxt_valid = 1'b1;
            end
            s_valid <= nxt_valid;
            s_data  <= nxt;
        end
    end

    always @(posedge aclk) begin : watch
        out_word_t want;
        logic      quiet;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, removed_value", m_data.removed_value, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.removed_value !== want.removed_value) begin
                        report_mismatch("removed_value", m_data.removed_value,
                                        want.removed_value);
                    end
                    if (m_data.status !== want.status) begin
                        report_mismatch("status", m_data.status, want.status);
                    end
                    if (m_data.count !== want.count) begin
                        report_mismatch("count", m_data.count, want.count);
                    end
                end
                results_checked++;
            end
            quiet = (results_checked >= QUIET_LO) && (results_checked < QUIET_HI);
            m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int added;
        int burst;
        int mode;
        int ins_pct;

        // Directed part: empty remove, a full load with extremes and ties,
        // a rejected insert, then a few removes.
        add_word(OP_REMOVE, 32'sd0);
        add_word(OP_INSERT, 32'sh7FFF_FFFF);
        add_word(OP_INSERT, 32'sh8000_0000);
        add_word(OP_INSERT, 32'sd0);
        add_word(OP_INSERT, -32'sd1);
        add_word(OP_INSERT, 32'sd1);
        add_word(OP_INSERT, 32'sd0);
        add_word(OP_INSERT, 32'sh5555_5555);
        add_word(OP_INSERT, 32'shAAAA_AAAA);
        add_word(OP_INSERT, 32'sh7FFF_FFFF);
        add_word(OP_INSERT, 32'sh8000_0000);
        add_word(OP_INSERT, 32'sd100);
        add_word(OP_INSERT, -32'sd100);
        add_word(OP_INSERT, 32'sd7);
        add_word(OP_INSERT, 32'sd6);
        add_word(OP_INSERT, 32'sd5);
        add_word(OP_INSERT, 32'sd4);
        add_word(OP_INSERT, 32'sd3);
        add_word(OP_REMOVE, 32'sh1234_5678);
        add_word(OP_REMOVE, 32'sd0);
        add_word(OP_REMOVE, 32'sd0);

        // Random part in bursts that lean toward filling or draining the queue, or are balanced.
        added = 0;
        while (added < RANDOM_ITEMS) begin
            mode  = $urandom_range(0, 3);
            burst = (mode < 2) ? $urandom_range(10, 24) : $urandom_range(5, 20);
            ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 99) < ins_pct) begin
                    add_word(OP_INSERT, pick_value());
                end else begin
                    add_word(OP_REMOVE, $signed($urandom));
                end
                added++;
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() > 0 || s_valid || expected_words.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Checked %0d result words from %0d input words in %0d cycles.",
                 results_checked, words_sent, cycles);
        $display("Inserts %0d, removes %0d, full rejects %0d, empty removes %0d.",
                 inserts_ok, removes_ok, full_rejects, empty_removes);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
